[src/bounded_deque_engine_unit_assert.svh]
//------------------------------------------------------------------------------
// Assertion macros for the bounded deque engine
// Shorthand for clocked checks, disabled while reset is asserted.
//------------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BDE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bde assertion failed");

// Next-cycle implication.
`define BDE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bde assertion failed");

`endif

[src/bde_pkg.sv]
//------------------------------------------------------------------------------
// bde_pkg
// Types and constants shared by the bounded deque engine modules.
//------------------------------------------------------------------------------
package bde_pkg;

  localparam int BDE_DEPTH   = 16;
  localparam int VALUE_WIDTH = 32;

  // Command kind codes as they arrive on the input port.
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
  localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
  localparam logic [2:0] KIND_LIST       = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_LIST       = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_POP_FRONT  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]                    kind;
    logic signed [VALUE_WIDTH-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                       status;
    logic signed [VALUE_WIDTH-1:0] element;
    logic                          last;
  } res_t;

  // Entry of the command queue between front and back.
  typedef struct packed {
    op_t                    op;
    logic [VALUE_WIDTH-1:0] value;
  } qent_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic  valid;
    qent_t ent;
  } qhead_t;

endpackage

[src/bde_front.sv]
//------------------------------------------------------------------------------
// bde_front
// Accepts commands, decodes the kind, drops unknown kinds and holds decoded
// commands in a two-entry queue for the back end.
//------------------------------------------------------------------------------
module bde_front
  import bde_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  cmd_t   in_cmd,
  output qhead_t head,
  input  logic   pop
);

  qent_t      slot_r [2];
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       known;
  op_t        dec_op;
  logic       push;
  logic       do_pop;

  always_comb begin
    known  = 1'b1;
    dec_op = OP_PUSH_BACK;
    unique case (in_cmd.kind)
      KIND_PUSH_BACK:  dec_op = OP_PUSH_BACK;
      KIND_PUSH_FRONT: dec_op = OP_PUSH_FRONT;
      KIND_LIST:       dec_op = OP_LIST;
      KIND_POP_BACK:   dec_op = OP_POP_BACK;
      KIND_POP_FRONT:  dec_op = OP_POP_FRONT;
      default:         known  = 1'b0;
    endcase
  end

  assign busy   = (cnt_r == 2'd2);
  assign push   = start && !busy && known;
  assign do_pop = pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.ent   = slot_r[rd_ptr_r];

  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= '{op: dec_op, value: in_cmd.value};
    end
  end

endmodule

[src/bde_back.sv]
//------------------------------------------------------------------------------
// bde_back
// Executes queued commands on the ring store: pushes and pops from the run state,
// listings one element per cycle through the registered read port.
//------------------------------------------------------------------------------
`include "bounded_deque_engine_unit_assert.svh"

module bde_back
  import bde_pkg::*;
#(
  parameter int DEPTH = BDE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  qhead_t head,
  output logic   pop,
  output logic   out_valid,
  output res_t   out_res
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_LIST = 2'b10
  } state_t;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  state_t           st_r, st_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             sim_vld_r, sim_vld_nxt;
  status_t          sim_stat_r, sim_stat_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             rd_last_r, rd_last_nxt;
  logic [VALUE_WIDTH-1:0] rd_data_r;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [IDX_W-1:0] rd_addr;
  logic             is_full, is_empty;
  logic [IDX_W-1:0] front_dec, front_inc;
  logic [CNT_W:0]   back_sum, list_sum;
  logic [IDX_W-1:0] back_pos, list_pos;

  assign is_full  = (occ_r == DEPTH_CNT);
  assign is_empty = (occ_r == '0);

  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;

  // Ring position = (front + offset) mod DEPTH, offset at most DEPTH.
  assign back_sum = {{(CNT_W + 1 - IDX_W){1'b0}}, front_r} + {1'b0, occ_r};
  assign list_sum = {{(CNT_W + 1 - IDX_W){1'b0}}, front_r} + {1'b0, idx_r};
  assign back_pos = (back_sum >= {1'b0, DEPTH_CNT}) ?
                    IDX_W'(back_sum - {1'b0, DEPTH_CNT}) : IDX_W'(back_sum);
  assign list_pos = (list_sum >= {1'b0, DEPTH_CNT}) ?
                    IDX_W'(list_sum - {1'b0, DEPTH_CNT}) : IDX_W'(list_sum);
  assign rd_addr  = list_pos;

  always_comb begin
    st_nxt       = st_r;
    front_nxt    = front_r;
    occ_nxt      = occ_r;
    idx_nxt      = idx_r;
    sim_vld_nxt  = 1'b0;
    sim_stat_nxt = STAT_OK;
    rd_vld_nxt   = 1'b0;
    rd_last_nxt  = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = back_pos;
    pop          = 1'b0;
    unique case (st_r)
      ST_RUN: begin
        if (head.valid) begin
          pop         = 1'b1;
          sim_vld_nxt = 1'b1;
          unique case (head.ent.op)
            OP_PUSH_BACK: begin
              if (is_full) begin
                sim_stat_nxt = STAT_FULL;
              end else begin
                mem_we  = 1'b1;
                occ_nxt = occ_r + 1'b1;
              end
            end
            OP_PUSH_FRONT: begin
              if (is_full) begin
                sim_stat_nxt = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wa    = front_dec;
                front_nxt = front_dec;
                occ_nxt   = occ_r + 1'b1;
              end
            end
            OP_LIST: begin
              if (is_empty) begin
                sim_stat_nxt = STAT_EMPTY;
              end else begin
                sim_vld_nxt = 1'b0;
                idx_nxt     = '0;
                st_nxt      = ST_LIST;
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                sim_stat_nxt = STAT_EMPTY;
              end else begin
                occ_nxt = occ_r - 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                sim_stat_nxt = STAT_EMPTY;
              end else begin
                front_nxt = front_inc;
                occ_nxt   = occ_r - 1'b1;
              end
            end
            default: begin
              sim_vld_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_LIST: begin
        rd_vld_nxt  = 1'b1;
        rd_last_nxt = (idx_r + 1'b1 == occ_r);
        idx_nxt     = idx_r + 1'b1;
        if (rd_last_nxt) begin
          st_nxt = ST_RUN;
        end
      end
      default: begin
        st_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_RUN;
      front_r   <= '0;
      occ_r     <= '0;
      idx_r     <= '0;
      sim_vld_r <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      front_r   <= front_nxt;
      occ_r     <= occ_nxt;
      idx_r     <= idx_nxt;
      sim_vld_r <= sim_vld_nxt;
      rd_vld_r  <= rd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sim_stat_r <= sim_stat_nxt;
    rd_last_r  <= rd_last_nxt;
  end

  // Ring store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= head.ent.value;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid       = sim_vld_r || rd_vld_r;
  assign out_res.status  = rd_vld_r ? STAT_OK : sim_stat_r;
  assign out_res.element = rd_vld_r ? rd_data_r : '0;
  assign out_res.last    = rd_vld_r ? rd_last_r : 1'b1;

  `BDE_ASSERT_IMP(a_occ_bound, 1'b1, occ_r <= DEPTH_CNT)
  `BDE_ASSERT_IMP(a_one_source, 1'b1, !(sim_vld_r && rd_vld_r))
  `BDE_ASSERT_NXT(a_list_holds_occ, st_r == ST_LIST, $stable(occ_r) && $stable(front_r))
  `BDE_ASSERT_IMP(a_no_pop_in_list, st_r == ST_LIST, !pop)

endmodule

[src/bounded_deque_engine_unit.sv]
//------------------------------------------------------------------------------
// bounded_deque_engine_unit
// Bounded double-ended queue of signed values held in a ring store.
//------------------------------------------------------------------------------
// A command transaction is taken on a clock edge where start is high and busy
// is low; busy rises only while the two-entry command queue is full. Kinds 0..4
// are push back, push front, list, pop back, pop front; other kinds are
// dropped at the input and give no result. Results come out on out_valid for
// exactly one cycle and cannot be held off. A push or pop is queued, then
// executed and its result registered; the back end finishes one such command
// per cycle when not running a listing. A listing of N held elements occupies
// the back end for a setup step, then one ring read per element, and emits
// N results, front first, last set on the final one; an empty listing, a
// pop on an empty queue and a push on a full queue each give one status-only
// result. The ring store comes up undefined and needs no clearing after reset.
//------------------------------------------------------------------------------
module bounded_deque_engine_unit
  import bde_pkg::*;
#(
  parameter int DEPTH = BDE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  cmd_t in_cmd,
  output logic out_valid,
  output res_t out_res
);

  qhead_t head;   // oldest queued command
  logic   pop;    // back end takes the head

  // Front: decode and buffer command transactions.
  bde_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .in_cmd (in_cmd),
    .head   (head),
    .pop    (pop)
  );

  // Back: ring store, indices and result registers.
  bde_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

[verif/bounded_deque_engine_unit_tb.sv]
//------------------------------------------------------------------------------
// bounded_deque_engine_unit_tb
// Self-checking bench for the bounded deque engine. Commands go in through
// the start/busy handshake, and a behavioral deque model predicts each result
// transaction. A monitor compares every strobed result field by field with
// the oldest pending prediction. Directed tests cover empty, full and extreme
// values, then weighted random traffic fills and drains the ring.
//------------------------------------------------------------------------------
module bounded_deque_engine_unit_tb;
  import bde_pkg::*;

  // Clock and handshake signals. Every input is driven from time zero.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  cmd_t in_cmd = '0;
  logic out_valid;
  res_t out_res;

  // Traffic modes for the random phase.
  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  localparam int RANDOM_CMDS   = 455;   // with the directed part, about 480
  localparam int DRAIN_CYCLES  = 2 * BDE_DEPTH + 8;
  localparam int TIMEOUT_TICKS = 3_000_000;

  // Behavioral model of the deque: ring contents, front slot and fill count.
  logic signed [VALUE_WIDTH-1:0] ring_store [BDE_DEPTH];
  int ring_front = 0;
  int ring_count = 0;

  // Results the block still owes, oldest first.
  res_t pending_results[$];

  int mismatch_count = 0;

  // Sender pacing: bursts of back-to-back commands split by idle gaps.
  int burst_left = 1;
  bit gaps_on = 1'b1;

  bounded_deque_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // 12-unit clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one accepted command to the model and queue what it must produce.
  // Push and pop give one status result; a listing gives one result per held
  // element, front first, or one empty status when nothing is held.
  function automatic void predict_deque(cmd_t cmd);
    res_t r;
    r.status  = STAT_OK;
    r.element = '0;
    r.last    = 1'b1;
    case (cmd.kind)
      KIND_PUSH_BACK: begin
        if (ring_count >= BDE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          ring_store[(ring_front + ring_count) % BDE_DEPTH] = cmd.value;
          ring_count++;
        end
      end
      KIND_PUSH_FRONT: begin
        if (ring_count >= BDE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          ring_front = (ring_front + BDE_DEPTH - 1) % BDE_DEPTH;
          ring_store[ring_front] = cmd.value;
          ring_count++;
        end
      end
      KIND_LIST: begin
        if (ring_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (int i = 0; i < ring_count; i++) begin
            r.element = ring_store[(ring_front + i) % BDE_DEPTH];
            r.last    = (i == ring_count - 1);
            pending_results.push_back(r);
          end
          return;
        end
      end
      KIND_POP_BACK: begin
        if (ring_count == 0) r.status = STAT_EMPTY;
        else ring_count--;
      end
      KIND_POP_FRONT: begin
        if (ring_count == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          ring_front = (ring_front + 1) % BDE_DEPTH;
          ring_count--;
        end
      end
      default: return;   // unknown kinds are dropped without a result
    endcase
    pending_results.push_back(r);
  endfunction

  // Between bursts, drop start for a random number of cycles (if enabled).
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Drive one command transaction and hold it until busy is low at a rising
  // edge. start stays high into the next command when the burst continues.
  task automatic send_cmd(input logic [2:0] kind,
                          input logic signed [VALUE_WIDTH-1:0] value);
    cmd_t cmd;
    cmd.kind  = kind;
    cmd.value = value;
    @(negedge clk);
    start  <= 1'b1;
    in_cmd <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_deque(cmd);
    pace_sender();
  endtask

  task automatic report_failure(input string what, input res_t got, input res_t want);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] %s: got status=%0d element=%0d last=%0b, want status=%0d element=%0d last=%0b",
               $time, what, got.status, got.element, got.last,
               want.status, want.element, want.last);
  endtask

  // Result monitor: results cannot be held off, so every strobed transaction
  // is taken at the edge that ends its cycle.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_failure("unexpected result", out_res, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_res.status !== want.status || out_res.element !== want.element ||
            out_res.last !== want.last)
          report_failure("result mismatch", out_res, want);
      end
    end
  end

  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      1:       return {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Empty-queue cases: listing, pop back and pop front all report empty.
  task automatic test_empty_queue();
    send_cmd(KIND_LIST, '0);
    send_cmd(KIND_POP_BACK, $urandom);
    send_cmd(KIND_POP_FRONT, $urandom);
  endtask

  // Extreme values at both ends, listed, then popped from both ends.
  task automatic test_value_extremes();
    send_cmd(KIND_PUSH_BACK, {1'b0, {(VALUE_WIDTH-1){1'b1}}});
    send_cmd(KIND_PUSH_FRONT, {1'b1, {(VALUE_WIDTH-1){1'b0}}});
    send_cmd(KIND_PUSH_BACK, '0);
    send_cmd(KIND_PUSH_FRONT, '1);
    send_cmd(KIND_LIST, $urandom);
    send_cmd(KIND_POP_FRONT, '0);
    send_cmd(KIND_POP_BACK, '0);
  endtask

  // Fill to capacity from both ends, refuse pushes at either end, list all.
  task automatic test_full_queue();
    while (ring_count < BDE_DEPTH)
      send_cmd(ring_count[0] ? KIND_PUSH_FRONT : KIND_PUSH_BACK, $urandom);
    send_cmd(KIND_PUSH_BACK, $urandom);
    send_cmd(KIND_PUSH_FRONT, $urandom);
    send_cmd(KIND_LIST, '0);
  endtask

  // Kinds 5..7 must be dropped without a result or a state change.
  task automatic test_unknown_kinds();
    for (int k = 5; k <= 7; k++)
      send_cmd(3'(k), $urandom);
  endtask

  // Weighted random traffic in segments that favor filling, draining or a
  // mix, so the ring wraps and hits both full and empty repeatedly. Some
  // segments run with no sender gaps at all.
  task automatic test_random_traffic(input int n_cmds);
    traffic_mode_t mode;
    int sent;
    int seg_left;
    int roll;
    logic [2:0] kind;
    sent = 0;
    seg_left = 0;
    mode = MODE_MIXED;
    while (sent < n_cmds) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 40);
        mode     = traffic_mode_t'($urandom_range(0, 2));
        gaps_on  = ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      case (mode)
        MODE_FILL:  roll = (roll < 60) ? 0 : (roll < 80) ? 1 : (roll < 93) ? 2 : 3;
        MODE_DRAIN: roll = (roll < 20) ? 0 : (roll < 78) ? 1 : (roll < 92) ? 2 : 3;
        default:    roll = (roll < 40) ? 0 : (roll < 75) ? 1 : (roll < 93) ? 2 : 3;
      endcase
      case (roll)
        0:       kind = $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
        1:       kind = $urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_BACK;
        2:       kind = KIND_LIST;
        default: kind = 3'($urandom_range(5, 7));
      endcase
      send_cmd(kind, pick_value());
      sent++;
      seg_left--;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    // Synchronous reset, released away from the edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_value_extremes();
    test_full_queue();
    test_unknown_kinds();
    test_random_traffic(RANDOM_CMDS);

    @(negedge clk);
    start <= 1'b0;

    // Let the block drain, then keep watching for stray results.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("bounded_deque_engine_unit test passed");
    else
      $display("bounded_deque_engine_unit test failed");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #TIMEOUT_TICKS;
    $display("bounded_deque_engine_unit test failed");
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/bde_pkg.sv
src/bde_front.sv
src/bde_back.sv
src/bounded_deque_engine_unit.sv
verif/bounded_deque_engine_unit_tb.sv
